// File: hw/rtl/snsel_pkg.sv
// Shared types and constants for the strongest-neighbour top-3 select block.
// No dependencies; imported by snsel_cell, strongest_neighbor_top3_select and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package snsel_pkg;

  localparam int KEPT_SLOTS = 3;
  localparam int OUT_SLOTS  = 3;
  localparam int FILL_W     = $clog2(KEPT_SLOTS + 1);
  localparam int CNT_W      = (FILL_W > 2) ? FILL_W : 2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_USED    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STATION_LIMIT = CFG_IDX_W'(1);

  localparam logic [1:0]  SLOTS_USED_RST    = 2'd2;
  localparam logic [1:0]  SLOTS_USED_MIN    = 2'd2;
  localparam logic [12:0] STATION_LIMIT_RST = 13'd1024;

  localparam logic [7:0] CH_LOW     = 8'd1;
  localparam logic [7:0] CH_MID     = 8'd6;
  localparam logic [7:0] CH_HIGH    = 8'd11;
  localparam logic [7:0] CH_LOW_TOP = 8'd3;
  localparam logic [7:0] CH_MID_TOP = 8'd8;
  localparam logic [7:0] CH_HI_TOP  = 8'd13;

  typedef struct packed {
    logic signed [7:0] signal_strength;
    logic [11:0]       neighbor_id;
    logic [7:0]        neighbor_channel;
    logic              report_valid;
    logic              list_end;
  } in_item_t;

  typedef struct packed {
    logic [11:0] first_id;
    logic [7:0]  first_channel;
    logic [11:0] second_id;
    logic [7:0]  second_channel;
    logic [11:0] third_id;
    logic [7:0]  third_channel;
    logic [1:0]  found_count;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic signed [7:0] strength;
    logic [11:0]       id;
    logic [7:0]        channel;
  } slot_t;

  // handoff from one cell to its right-hand neighbour
  typedef struct packed {
    logic  take;
    slot_t slot;
  } link_t;

endpackage

`default_nettype wire

// File: hw/rtl/snsel_cell.sv
// One ranking cell of the insertion chain: holds a single kept report.
// Depends on snsel_pkg (slot_t, link_t).
`timescale 1ns / 1ps
`default_nettype none

module snsel_cell
  import snsel_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  ins_en,
  input  wire logic  clear,
  input  wire slot_t new_slot,
  input  wire link_t left_i,
  output link_t      link_o,
  output slot_t      slot_ins
);

  slot_t slot_r;
  slot_t slot_nxt;
  logic  take;

  // empty cell always accepts; later report wins ties
  assign take = !slot_r.valid || (new_slot.strength >= slot_r.strength);

  always_comb begin
    if (!ins_en) begin
      slot_ins = slot_r;
    end else if (left_i.take) begin
      slot_ins = left_i.slot;
    end else if (take) begin
      slot_ins = new_slot;
    end else begin
      slot_ins = slot_r;
    end
  end

  always_comb begin
    slot_nxt       = slot_ins;
    slot_nxt.valid = slot_ins.valid && !clear;
  end

  assign link_o.take = take;
  assign link_o.slot = slot_r;

  // only the valid bit is reset; the payload is ignored while invalid
  always_ff @(posedge clk) begin
    slot_r.strength <= slot_nxt.strength;
    slot_r.id       <= slot_nxt.id;
    slot_r.channel  <= slot_nxt.channel;
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/strongest_neighbor_top3_select.sv
// Strongest-neighbour select: top level with cell chain, config and output register.
// Depends on snsel_pkg and snsel_cell.
// A closing item's result is registered and valid in the cycle after its transfer.
// Throughput: one item per cycle; each report is ranked in a single pass of the
// cell chain (parallel compare in every cell, shift by one towards the weak end).
// Input stalls only while a result is held and the output side stalls.
// Reset (synchronous, rst_n low): all slots empty, slots_used = 2, station_limit = 1024.
`timescale 1ns / 1ps
`default_nettype none

module strongest_neighbor_top3_select
  import snsel_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]  slots_used_r,    slots_used_nxt;
  logic [12:0] station_limit_r, station_limit_nxt;

  always_comb begin
    slots_used_nxt    = slots_used_r;
    station_limit_nxt = station_limit_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_SLOTS_USED:    slots_used_nxt    = cfg_wdata[1:0];
        REG_STATION_LIMIT: station_limit_nxt = cfg_wdata[12:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r    <= SLOTS_USED_RST;
      station_limit_r <= STATION_LIMIT_RST;
    end else begin
      slots_used_r    <= slots_used_nxt;
      station_limit_r <= station_limit_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: output register decouples the two sides
  // ---------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic in_xfer;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Insertion chain: cell 0 holds the strongest report
  // ---------------------------------------------------------------------------
  slot_t new_slot;
  logic  ins_en;
  logic  clear;
  link_t chain_w [KEPT_SLOTS+1];
  slot_t slot_ins [KEPT_SLOTS];

  assign new_slot.valid    = 1'b1;
  assign new_slot.strength = in_item.signal_strength;
  assign new_slot.id       = in_item.neighbor_id;
  assign new_slot.channel  = in_item.neighbor_channel;

  assign ins_en = in_xfer && in_item.report_valid;
  assign clear  = in_xfer && in_item.list_end;

  // nothing shifts into the head of the chain
  assign chain_w[0] = '0;

  for (genvar k = 0; k < KEPT_SLOTS; k++) begin : g_cell
    snsel_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ins_en   (ins_en),
      .clear    (clear),
      .new_slot (new_slot),
      .left_i   (chain_w[k]),
      .link_o   (chain_w[k+1]),
      .slot_ins (slot_ins[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Result formation from the post-insert slot contents
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] snap_channel(input logic [7:0] ch);
    if (ch <= CH_LOW_TOP)      return CH_LOW;
    else if (ch <= CH_MID_TOP) return CH_MID;
    else if (ch <= CH_HI_TOP)  return CH_HIGH;
    else                       return ch;
  endfunction

  logic [1:0]       report_lim;
  logic [CNT_W-1:0] fill_cnt;
  logic [1:0]       found;
  logic [11:0]      res_id [OUT_SLOTS];
  logic [7:0]       res_ch [OUT_SLOTS];

  // slots_used below two behaves as two
  assign report_lim = (slots_used_r < SLOTS_USED_MIN) ? SLOTS_USED_MIN : slots_used_r;

  // valid bits form a prefix, so their count is the fill level
  always_comb begin
    fill_cnt = '0;
    for (int k = 0; k < KEPT_SLOTS; k++) begin
      fill_cnt = fill_cnt + CNT_W'(slot_ins[k].valid);
    end
  end

  assign found = (fill_cnt < CNT_W'(report_lim)) ? fill_cnt[1:0] : report_lim;

  for (genvar s = 0; s < OUT_SLOTS; s++) begin : g_res
    if (s < KEPT_SLOTS) begin : g_kept
      logic reported;
      logic known;
      assign reported = slot_ins[s].valid && (2'(s) < report_lim);
      assign known    = (slot_ins[s].id != '0) && ({1'b0, slot_ins[s].id} < station_limit_r);
      assign res_id[s] = (reported && known)  ? slot_ins[s].id : '0;
      assign res_ch[s] = (reported && !known) ? snap_channel(slot_ins[s].channel) : '0;
    end else begin : g_none
      // no cell behind this slot
      assign res_id[s] = '0;
      assign res_ch[s] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  out_item_t out_item_r;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (clear) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      out_item_r.first_id       <= res_id[0];
      out_item_r.first_channel  <= res_ch[0];
      out_item_r.second_id      <= res_id[1];
      out_item_r.second_channel <= res_ch[1];
      out_item_r.third_id       <= res_id[2];
      out_item_r.third_channel  <= res_ch[2];
      out_item_r.found_count    <= found;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: tb/neighbour_rank_checker.sv
// Scoreboard for strongest_neighbor_top3_select: mirrors the kept-slot ranking and both registers.
// Depends on snsel_pkg; watches the input, result and configuration ports of the block.
`timescale 1ns / 1ps

module neighbour_rank_checker
  import snsel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    lists_pending
);

  logic signed [7:0] kept_strength [KEPT_SLOTS];
  logic [11:0]       kept_id       [KEPT_SLOTS];
  logic [7:0]        kept_channel  [KEPT_SLOTS];
  int                kept_fill;
  logic [1:0]        slots_used_now;
  logic [12:0]       station_limit_now;
  out_item_t         expected_lists [$];

  function automatic logic [7:0] channel_grid(input logic [7:0] ch);
    if (ch <= CH_LOW_TOP) return CH_LOW;
    if (ch <= CH_MID_TOP) return CH_MID;
    if (ch <= CH_HI_TOP) return CH_HIGH;
    return ch;
  endfunction

  function automatic void empty_slots();
    for (int k = 0; k < KEPT_SLOTS; k++) begin
      kept_strength[k] = '0;
      kept_id[k] = '0;
      kept_channel[k] = '0;
    end
    kept_fill = 0;
  endfunction

  // new report goes above every kept one of equal or lower strength
  function automatic void rank_report(input in_item_t it);
    int  pos;
    bit  found;
    pos = kept_fill;
    found = 1'b0;
    for (int k = 0; k < kept_fill; k++) begin
      if (!found && $signed(it.signal_strength) >= $signed(kept_strength[k])) begin
        pos = k;
        found = 1'b1;
      end
    end
    if (pos < KEPT_SLOTS) begin
      for (int k = KEPT_SLOTS - 1; k > pos; k--) begin
        kept_strength[k] = kept_strength[k-1];
        kept_id[k] = kept_id[k-1];
        kept_channel[k] = kept_channel[k-1];
      end
      kept_strength[pos] = it.signal_strength;
      kept_id[pos] = it.neighbor_id;
      kept_channel[pos] = it.neighbor_channel;
      if (kept_fill < KEPT_SLOTS) kept_fill++;
    end
  endfunction

  function automatic out_item_t close_list();
    out_item_t   r;
    int          shown;
    logic [11:0] ids [OUT_SLOTS];
    logic [7:0]  chs [OUT_SLOTS];
    shown = (slots_used_now < SLOTS_USED_MIN) ? int'(SLOTS_USED_MIN) : int'(slots_used_now);
    if (shown > OUT_SLOTS) shown = OUT_SLOTS;
    if (shown > kept_fill) shown = kept_fill;
    for (int s = 0; s < OUT_SLOTS; s++) begin
      ids[s] = '0;
      chs[s] = '0;
      if (s < shown && s < KEPT_SLOTS) begin
        if (kept_id[s] != 0 && {1'b0, kept_id[s]} < station_limit_now) ids[s] = kept_id[s];
        else chs[s] = channel_grid(kept_channel[s]);
      end
    end
    r.first_id       = ids[0];
    r.first_channel  = chs[0];
    r.second_id      = ids[1];
    r.second_channel = chs[1];
    r.third_id       = ids[2];
    r.third_channel  = chs[2];
    r.found_count    = shown[1:0];
    empty_slots();
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      empty_slots();
      slots_used_now = SLOTS_USED_RST;
      station_limit_now = STATION_LIMIT_RST;
      expected_lists.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SLOTS_USED:    slots_used_now = cfg_wdata[1:0];
          REG_STATION_LIMIT: station_limit_now = cfg_wdata;
          default: ;
        endcase
      end
      // results are registered after their closing item's transfer, so check before taking new input
      if (out_valid && !out_stall) begin
        if (expected_lists.size() == 0) begin
          $error("result transfer with no closed list waiting");
          mismatch_count++;
        end else begin
          want = expected_lists.pop_front();
          check_field("first_id", want.first_id, out_item.first_id);
          check_field("first_channel", want.first_channel, out_item.first_channel);
          check_field("second_id", want.second_id, out_item.second_id);
          check_field("second_channel", want.second_channel, out_item.second_channel);
          check_field("third_id", want.third_id, out_item.third_id);
          check_field("third_channel", want.third_channel, out_item.third_channel);
          check_field("found_count", want.found_count, out_item.found_count);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_item.report_valid) rank_report(in_item);
        if (in_item.list_end) expected_lists.push_back(close_list());
      end
    end
    lists_pending <= expected_lists.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the strongest_neighbor_top3_select testbench: clock, reset, stimulus and verdict.
// Depends on snsel_pkg, the block itself and neighbour_rank_checker.
`timescale 1ns / 1ps

module tb_top;
  import snsel_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int ITEM_TARGET  = 1650;
  localparam int SETTLE       = 3;     // result is registered, valid in the cycle after its transfer
  localparam int PHASES       = 8;
  // an index past the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int lists_pending;
  int cycle_count = 0;
  int hold_left = 0;
  int items_sent = 0;
  int limit_now = STATION_LIMIT_RST;
  bit calm = 1'b0;      // when set, neither side idles

  always #10 clk = ~clk;

  strongest_neighbor_top3_select DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  neighbour_rank_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (fail_count),
    .lists_pending  (lists_pending)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: after each transfer draw a random hold, which may be zero; the countdown
  // runs whether or not a result is waiting, so stalls land on every phase
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) hold_left = calm ? 0 : $urandom_range(0, 3);
      else if (hold_left > 0) hold_left--;
      out_stall <= (hold_left != 0);
    end
  end

  function automatic in_item_t neighbour(input int strength, input int id, input int ch,
                                         input bit valid, input bit last);
    in_item_t it;
    it.signal_strength  = 8'(strength);
    it.neighbor_id      = 12'(id);
    it.neighbor_channel = 8'(ch);
    it.report_valid     = valid;
    it.list_end         = last;
    return it;
  endfunction

  // strengths bunch up often so that ties and equal-weakest cases come round
  function automatic in_item_t random_report();
    in_item_t it;
    case ($urandom_range(0, 3))
      0:       it.signal_strength = 8'($urandom_range(0, 6) - 3);
      1:       it.signal_strength = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      default: it.signal_strength = 8'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       it.neighbor_id = '0;
      1:       it.neighbor_id = 12'($urandom_range(1, 15));
      2:       it.neighbor_id = 12'(limit_now - 1 + $urandom_range(0, 1));
      default: it.neighbor_id = 12'($urandom);
    endcase
    it.neighbor_channel = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    it.report_valid = 1'b1;
    it.list_end = 1'b0;
    return it;
  endfunction

  // one transfer on the input channel, after a random idle gap, which may be none
  task automatic send_item(input in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (it.report_valid || it.list_end) items_sent++;
  endtask

  // hold off until every closed list has come back, then let the pipe drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (lists_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_STATION_LIMIT) limit_now = value;
  endtask

  // a list of 0..6 reports; the last report often carries the close itself,
  // with the odd ignored item mixed in as noise
  task automatic send_list();
    in_item_t it;
    int       n;
    bit       closed;
    n = $urandom_range(0, 6);
    closed = 1'b0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = random_report();
        it.report_valid = 1'b0;
        send_item(it);
      end
      it = random_report();
      if (k == n - 1 && $urandom_range(0, 1)) begin
        it.list_end = 1'b1;
        closed = 1'b1;
      end
      send_item(it);
    end
    if (!closed) begin
      it = random_report();
      it.report_valid = 1'b0;
      it.list_end = 1'b1;
      send_item(it);
    end
  endtask

  initial begin
    int slots_pick [PHASES];
    int limit_pick [PHASES];
    slots_pick = '{2, 3, 0, 3, 2, 1, 3, 2};
    limit_pick = '{1024, 4096, 1, 0, 8191, 2048, -1, 4095};

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: two slots, nonzero ids below 1024 known
    send_item(neighbour(0, 0, 0, 0, 1));          // close on an empty list
    send_item(neighbour(-1, 4095, 255, 0, 0));    // neither report nor close
    send_item(neighbour(127, 4095, 255, 1, 0));   // unknown id, channel passes
    send_item(neighbour(127, 1023, 9, 1, 0));     // tie: later report ranks higher
    send_item(neighbour(0, 0, 0, 1, 0));
    send_item(neighbour(-128, 0, 14, 1, 0));      // weaker than all kept: dropped
    send_item(neighbour(0, 0, 4, 1, 1));          // report and close together
    settle();

    // three slots, every nonzero 12-bit id known
    write_reg(REG_SLOTS_USED, 3);
    write_reg(REG_STATION_LIMIT, 4096);
    send_item(neighbour(5, 4095, 8, 1, 0));
    send_item(neighbour(-5, 0, 13, 1, 0));
    send_item(neighbour(100, 2048, 3, 1, 0));
    send_item(neighbour(-128, 0, 200, 0, 1));     // bare close, junk in the other fields
    send_item(neighbour(7, 0, 14, 1, 1));         // fewer reports than slots
    settle();

    // slots_used under two, and a limit of zero: nothing counts as known
    write_reg(REG_SLOTS_USED, 0);
    write_reg(REG_STATION_LIMIT, 0);
    send_item(neighbour(1, 1, 1, 1, 0));
    send_item(neighbour(2, 4095, 2, 1, 0));
    send_item(neighbour(3, 77, 4, 1, 0));
    send_item(neighbour(0, 0, 0, 0, 1));
    settle();

    // limit of one, and a write past the register list that must change nothing
    write_reg(REG_SLOTS_USED, 1);
    write_reg(REG_STATION_LIMIT, 1);
    write_reg(REG_UNUSED, 3);
    send_item(neighbour(-100, 1, 8, 1, 0));
    send_item(neighbour(-100, 0, 9, 1, 0));
    send_item(neighbour(50, 2, 10, 1, 1));
    settle();
    write_reg(REG_STATION_LIMIT, 2);
    send_item(neighbour(10, 1, 0, 1, 1));
    settle();

    // random lists, one register setting per phase; every third phase runs flat out
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_SLOTS_USED, slots_pick[p]);
      write_reg(REG_STATION_LIMIT,
                limit_pick[p] < 0 ? int'($urandom_range(1, 4096)) : limit_pick[p]);
      calm = (p % 3 == 2);
      while (items_sent < (p + 1) * ITEM_TARGET / PHASES) send_list();
      settle();
    end
    calm = 1'b0;

    if (fail_count == 0 && lists_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/snsel_pkg.sv
hw/rtl/snsel_cell.sv
hw/rtl/strongest_neighbor_top3_select.sv
tb/neighbour_rank_checker.sv
tb/tb_top.sv
